>>> rtl/kpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpq_pkg
// Shared types, constants and helpers for the keypad scanner with key queue.
// ----------------------------------------------------------------------------
package kpq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NIB_W  = 4;
    localparam int NUM_COLS = 4;
    localparam int CODE_W = 5;
    localparam int OUT_FILL_W = 4;

    // operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // row line patterns, active low
    localparam logic [NIB_W-1:0] NIB_IDLE = 4'hF;
    localparam logic [NIB_W-1:0] NIB_ROW0 = 4'hE;
    localparam logic [NIB_W-1:0] NIB_ROW1 = 4'hD;
    localparam logic [NIB_W-1:0] NIB_ROW2 = 4'hB;
    localparam logic [NIB_W-1:0] NIB_ROW3 = 4'h7;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
    } t_key;

    typedef struct packed {
        logic [CODE_W-1:0]     key_code;
        logic                  key_pushed;
        logic                  key_dropped;
        logic [OUT_FILL_W-1:0] queue_fill;
    } t_result;

    function automatic logic [1:0] row_of(input logic [NIB_W-1:0] nib);
        logic [1:0] row;
        unique case (nib)
            NIB_ROW1: row = 2'd1;
            NIB_ROW2: row = 2'd2;
            NIB_ROW3: row = 2'd3;
            default:  row = 2'd0;
        endcase
        return row;
    endfunction

endpackage
`default_nettype wire

>>> rtl/kpq_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpq_decode
// Picks the first active column and its row, and forms the key code.
// ----------------------------------------------------------------------------
module kpq_decode (
    input  wire logic [kpq_pkg::NIB_W-1:0] i_rows_col0,
    input  wire logic [kpq_pkg::NIB_W-1:0] i_rows_col1,
    input  wire logic [kpq_pkg::NIB_W-1:0] i_rows_col2,
    input  wire logic [kpq_pkg::NIB_W-1:0] i_rows_col3,
    output kpq_pkg::t_key                  o_key
);

    logic [kpq_pkg::NIB_W-1:0] nib;
    logic [1:0]                col;
    logic                      found;

    always_comb begin
        found = 1'b1;
        priority if (i_rows_col0 != kpq_pkg::NIB_IDLE) begin
            nib = i_rows_col0;
            col = 2'd0;
        end else if (i_rows_col1 != kpq_pkg::NIB_IDLE) begin
            nib = i_rows_col1;
            col = 2'd1;
        end else if (i_rows_col2 != kpq_pkg::NIB_IDLE) begin
            nib = i_rows_col2;
            col = 2'd2;
        end else begin
            nib   = i_rows_col3;
            col   = 2'd3;
            found = (i_rows_col3 != kpq_pkg::NIB_IDLE);
        end
    end

    assign o_key.found = found;
    assign o_key.code  = kpq_pkg::CODE_W'({kpq_pkg::row_of(nib), col})
                         + kpq_pkg::CODE_W'(1);

endmodule
`default_nettype wire

>>> rtl/kpq_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpq_queue
// Circular key queue: push on scan, pop on read, forms the result fields.
// ----------------------------------------------------------------------------
module kpq_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_operation,
    input  wire kpq_pkg::t_key i_key,
    output kpq_pkg::t_result o_result
);

    logic [kpq_pkg::CODE_W-1:0] r_store [kpq_pkg::QUEUE_DEPTH];
    logic [kpq_pkg::SLOT_W-1:0] r_wr_slot, n_wr_slot;
    logic [kpq_pkg::SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic [kpq_pkg::FILL_W-1:0] r_fill, n_fill;

    logic full;
    logic empty;
    logic push;
    logic pop;
    logic dropped;

    function automatic logic [kpq_pkg::SLOT_W-1:0] advance(
        input logic [kpq_pkg::SLOT_W-1:0] slot
    );
        logic [kpq_pkg::SLOT_W-1:0] nxt;
        if (slot == kpq_pkg::SLOT_W'(kpq_pkg::QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = slot + kpq_pkg::SLOT_W'(1);
        end
        return nxt;
    endfunction

    assign full    = (r_fill == kpq_pkg::FILL_W'(kpq_pkg::QUEUE_DEPTH));
    assign empty   = (r_fill == '0);
    assign push    = (i_operation == kpq_pkg::OP_SCAN) && i_key.found && !full;
    assign dropped = (i_operation == kpq_pkg::OP_SCAN) && i_key.found && full;
    assign pop     = (i_operation == kpq_pkg::OP_READ) && !empty;

    always_comb begin
        n_wr_slot = push ? advance(r_wr_slot) : r_wr_slot;
        n_rd_slot = pop ? advance(r_rd_slot) : r_rd_slot;
        n_fill    = r_fill;
        if (push) begin
            n_fill = r_fill + kpq_pkg::FILL_W'(1);
        end else if (pop) begin
            n_fill = r_fill - kpq_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_fill    <= '0;
        end else if (i_en) begin
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && push) begin
            r_store[r_wr_slot] <= i_key.code;
        end
    end

    assign o_result.key_code    = pop ? r_store[r_rd_slot] : '0;
    assign o_result.key_pushed  = push;
    assign o_result.key_dropped = dropped;
    assign o_result.queue_fill  = kpq_pkg::OUT_FILL_W'(n_fill);

endmodule
`default_nettype wire

>>> rtl/matrix_keypad_scan_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scan_fifo_unit
// 4x4 keypad scanner feeding an eight-entry key queue.
// ----------------------------------------------------------------------------
// Takes one request per clock unless o_in_stall is high, and returns one result
// per request. The request is captured in the input register, then passes
// through the column decode and queue update into the result register, which
// drives the outputs. The queue lives in flip-flops, so a request's pop sees
// a key pushed by the request just before it.
// A stalled result holds the input side only once the input register is
// also occupied.
module matrix_keypad_scan_fifo_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [kpq_pkg::NIB_W-1:0]      i_rows_col0,
    input  wire logic [kpq_pkg::NIB_W-1:0]      i_rows_col1,
    input  wire logic [kpq_pkg::NIB_W-1:0]      i_rows_col2,
    input  wire logic [kpq_pkg::NIB_W-1:0]      i_rows_col3,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    output      logic [kpq_pkg::CODE_W-1:0]     o_key_code,
    output      logic                           o_key_pushed,
    output      logic                           o_key_dropped,
    output      logic [kpq_pkg::OUT_FILL_W-1:0] o_queue_fill
);

    logic                      r_in_valid;
    logic                      r_op;
    logic [kpq_pkg::NIB_W-1:0] r_rows0;
    logic [kpq_pkg::NIB_W-1:0] r_rows1;
    logic [kpq_pkg::NIB_W-1:0] r_rows2;
    logic [kpq_pkg::NIB_W-1:0] r_rows3;

    logic             r_out_valid;
    kpq_pkg::t_result r_result;

    kpq_pkg::t_key    key;
    kpq_pkg::t_result result;
    logic             adv;
    logic             accept;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_rows0 <= i_rows_col0;
            r_rows1 <= i_rows_col1;
            r_rows2 <= i_rows_col2;
            r_rows3 <= i_rows_col3;
        end
    end

    kpq_decode u_decode (
        .i_rows_col0 (r_rows0),
        .i_rows_col1 (r_rows1),
        .i_rows_col2 (r_rows2),
        .i_rows_col3 (r_rows3),
        .o_key       (key)
    );

    kpq_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_operation (r_op),
        .i_key       (key),
        .o_result    (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_code    = r_result.key_code;
    assign o_key_pushed  = r_result.key_pushed;
    assign o_key_dropped = r_result.key_dropped;
    assign o_queue_fill  = r_result.queue_fill;

endmodule
`default_nettype wire

>>> dv/matrix_keypad_scan_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scan_fifo_unit_tb
// Drives scan and read requests into the keypad scanner, decodes each scan
// and tracks the key queue alongside the block, and checks every result
// field in order. The run steps through phases with and without idle cycles
// on either side.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_fifo_unit_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PER_PH = 175;

    typedef struct packed {
        logic                                               op;
        logic [kpq_pkg::NUM_COLS-1:0][kpq_pkg::NIB_W-1:0]   rows;
    } t_scan_req;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           i_operation   = kpq_pkg::OP_SCAN;
    logic [kpq_pkg::NIB_W-1:0]      i_rows_col0   = kpq_pkg::NIB_IDLE;
    logic [kpq_pkg::NIB_W-1:0]      i_rows_col1   = kpq_pkg::NIB_IDLE;
    logic [kpq_pkg::NIB_W-1:0]      i_rows_col2   = kpq_pkg::NIB_IDLE;
    logic [kpq_pkg::NIB_W-1:0]      i_rows_col3   = kpq_pkg::NIB_IDLE;
    logic                           i_out_stall   = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [kpq_pkg::CODE_W-1:0]     o_key_code;
    logic                           o_key_pushed;
    logic                           o_key_dropped;
    logic [kpq_pkg::OUT_FILL_W-1:0] o_queue_fill;

    t_scan_req          pending_reqs[$];
    kpq_pkg::t_result   due_results[$];
    t_scan_req          bus_req;
    bit                 rst_done     = 1'b0;
    int                 send_gap_pct = 0;
    int                 recv_gap_pct = 0;
    int                 errors       = 0;
    int                 cycles       = 0;

    logic [kpq_pkg::CODE_W-1:0] key_mem [kpq_pkg::QUEUE_DEPTH];
    int                         wr_slot = 0;
    int                         rd_slot = 0;
    int                         held    = 0;

    matrix_keypad_scan_fifo_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_rows_col0   (i_rows_col0),
        .i_rows_col1   (i_rows_col1),
        .i_rows_col2   (i_rows_col2),
        .i_rows_col3   (i_rows_col3),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_key_code    (o_key_code),
        .o_key_pushed  (o_key_pushed),
        .o_key_dropped (o_key_dropped),
        .o_queue_fill  (o_queue_fill)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // column priority decode and key queue update for one request
    function automatic kpq_pkg::t_result decode_and_queue(input t_scan_req r);
        kpq_pkg::t_result          res;
        logic [kpq_pkg::NIB_W-1:0] nib;
        logic [1:0]                row;
        logic [1:0]                col_hit;
        bit                        found;
        res     = '0;
        found   = 1'b0;
        nib     = kpq_pkg::NIB_IDLE;
        col_hit = 2'd0;
        if (r.op == kpq_pkg::OP_SCAN) begin
            for (int c = 0; c < kpq_pkg::NUM_COLS; c++) begin
                if (!found && r.rows[c] != kpq_pkg::NIB_IDLE) begin
                    found   = 1'b1;
                    nib     = r.rows[c];
                    col_hit = 2'(c);
                end
            end
            if (found) begin
                unique case (nib)
                    kpq_pkg::NIB_ROW1: row = 2'd1;
                    kpq_pkg::NIB_ROW2: row = 2'd2;
                    kpq_pkg::NIB_ROW3: row = 2'd3;
                    default:           row = 2'd0;
                endcase
                if (held >= kpq_pkg::QUEUE_DEPTH) begin
                    res.key_dropped = 1'b1;
                end else begin
                    key_mem[wr_slot] = kpq_pkg::CODE_W'({row, col_hit})
                                       + kpq_pkg::CODE_W'(1);
                    wr_slot          = (wr_slot + 1) % kpq_pkg::QUEUE_DEPTH;
                    held++;
                    res.key_pushed   = 1'b1;
                end
            end
        end else if (held != 0) begin
            res.key_code = key_mem[rd_slot];
            rd_slot      = (rd_slot + 1) % kpq_pkg::QUEUE_DEPTH;
            held--;
        end
        res.queue_fill = kpq_pkg::OUT_FILL_W'(held);
        return res;
    endfunction

    function automatic t_scan_req make_scan(input logic [kpq_pkg::NIB_W-1:0] c0,
                                            input logic [kpq_pkg::NIB_W-1:0] c1,
                                            input logic [kpq_pkg::NIB_W-1:0] c2,
                                            input logic [kpq_pkg::NIB_W-1:0] c3);
        t_scan_req r;
        r.op      = kpq_pkg::OP_SCAN;
        r.rows[0] = c0;
        r.rows[1] = c1;
        r.rows[2] = c2;
        r.rows[3] = c3;
        return r;
    endfunction

    function automatic t_scan_req random_scan();
        t_scan_req r;
        int        col;
        r.op = kpq_pkg::OP_SCAN;
        col  = $urandom_range(4);
        for (int c = 0; c < kpq_pkg::NUM_COLS; c++) begin
            if ($urandom_range(9) == 0)
                r.rows[c] = kpq_pkg::NIB_W'($urandom_range(15));
            else if (c < col)
                r.rows[c] = kpq_pkg::NIB_IDLE;
            else if (c == col && $urandom_range(9) < 7)
                r.rows[c] = ~(kpq_pkg::NIB_W'(1) << $urandom_range(3));
            else if (c == col)
                r.rows[c] = kpq_pkg::NIB_W'($urandom_range(14));
            else
                r.rows[c] = kpq_pkg::NIB_W'($urandom_range(15));
        end
        return r;
    endfunction

    function automatic t_scan_req random_read();
        t_scan_req r;
        r    = random_scan();
        r.op = kpq_pkg::OP_READ;
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_scan_req nxt;
        bit        accepted;
        accepted = i_in_valid && !o_in_stall;
        if (accepted)
            due_results.push_back(decode_and_queue(bus_req));
        if (!i_in_valid || accepted) begin
            if (rst_done && pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt         = pending_reqs.pop_front();
                bus_req     <= nxt;
                i_operation <= nxt.op;
                i_rows_col0 <= nxt.rows[0];
                i_rows_col1 <= nxt.rows[1];
                i_rows_col2 <= nxt.rows[2];
                i_rows_col3 <= nxt.rows[3];
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid  <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        kpq_pkg::t_result want;
        if (rst_done && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, key_code", int'(o_key_code), 0);
            end else begin
                want = due_results.pop_front();
                if (o_key_code !== want.key_code)
                    report_mismatch("key_code", int'(o_key_code), int'(want.key_code));
                if (o_key_pushed !== want.key_pushed)
                    report_mismatch("key_pushed", int'(o_key_pushed),
                                    int'(want.key_pushed));
                if (o_key_dropped !== want.key_dropped)
                    report_mismatch("key_dropped", int'(o_key_dropped),
                                    int'(want.key_dropped));
                if (o_queue_fill !== want.queue_fill)
                    report_mismatch("queue_fill", int'(o_queue_fill),
                                    int'(want.queue_fill));
            end
        end
        i_out_stall <= rst_done && ($urandom_range(99) < recv_gap_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("matrix_keypad_scan_fifo_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_scan_req rd;
        int        burst;
        bit        scanning;
        for (int i = 0; i < kpq_pkg::QUEUE_DEPTH; i++)
            key_mem[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        rst_done = 1'b1;

        rd      = '0;
        rd.op   = kpq_pkg::OP_READ;
        // empty read, no key, row and column extremes, several low bits, priority
        pending_reqs.push_back(rd);
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE,
                                         kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_ROW0, kpq_pkg::NIB_IDLE,
                                         kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE,
                                         kpq_pkg::NIB_IDLE, kpq_pkg::NIB_ROW3));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, 4'h0,
                                         kpq_pkg::NIB_ROW3, kpq_pkg::NIB_ROW2));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE,
                                         kpq_pkg::NIB_ROW1, kpq_pkg::NIB_ROW0));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_ROW2, 4'h0, 4'h0));
        pending_reqs.push_back(make_scan(4'h3, kpq_pkg::NIB_ROW1,
                                         kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE,
                                         4'h6, kpq_pkg::NIB_IDLE));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_ROW3, kpq_pkg::NIB_ROW3,
                                         kpq_pkg::NIB_ROW3, kpq_pkg::NIB_ROW3));
        // queue full: dropped keys
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE,
                                         kpq_pkg::NIB_IDLE, kpq_pkg::NIB_ROW3));
        pending_reqs.push_back(make_scan(4'h0, 4'h0, 4'h0, 4'h0));
        pending_reqs.push_back(make_scan(kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE,
                                         kpq_pkg::NIB_IDLE, kpq_pkg::NIB_IDLE));
        for (int i = 0; i < kpq_pkg::QUEUE_DEPTH + 2; i++)
            pending_reqs.push_back(rd);

        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0:       begin send_gap_pct = 0;  recv_gap_pct = 0;  end
                1:       begin send_gap_pct = 74; recv_gap_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_gap_pct = 74; end
                default: begin send_gap_pct = 26; recv_gap_pct = 26; end
            endcase
            scanning = 1'b1;
            for (int n = 0; n < ITEMS_PER_PH; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < ITEMS_PER_PH; b++, n++) begin
                    if ($urandom_range(9) < 2)
                        pending_reqs.push_back($urandom_range(1) ? random_read() : random_scan());
                    else
                        pending_reqs.push_back(scanning ? random_scan() : random_read());
                end
                scanning = ~scanning;
            end
            while (pending_reqs.size() != 0 || i_in_valid || due_results.size() != 0)
                @(negedge i_clk);
        end

        repeat (6) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("results never returned", 0, due_results.size());
        if (errors == 0)
            $display("matrix_keypad_scan_fifo_unit verification clean");
        else
            $display("matrix_keypad_scan_fifo_unit verification failed");
        $finish;
    end

endmodule
